[design/audio_dsp_command_dma_engine_assert.svh]
// ---------------------------------------------------------------------------
// audio dsp command dma engine assertion macros
// Short wrappers for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef AUDIO_DSP_COMMAND_DMA_ENGINE_ASSERT_SVH
`define AUDIO_DSP_COMMAND_DMA_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ADCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adce assertion failed");

// next-cycle implication, checked outside reset
`define ADCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adce assertion failed");

`endif

[design/adce_pkg.sv]
// ---------------------------------------------------------------------------
// adce_pkg
// Types, command codes and helper functions of the audio dsp engine.
// ---------------------------------------------------------------------------
package adce_pkg;

  localparam int FIFO_DEPTH_DEF = 16;

  // request types
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // port offsets
  localparam logic [3:0] PORT_RESET  = 4'h6;
  localparam logic [3:0] PORT_RDATA  = 4'hA;
  localparam logic [3:0] PORT_CMD    = 4'hC;
  localparam logic [3:0] PORT_STATUS = 4'hE;

  // commands
  localparam logic [7:0] CMD_NONE       = 8'h00;
  localparam logic [7:0] CMD_DIRECT_DAC = 8'h10;
  localparam logic [7:0] CMD_DMA_SINGLE = 8'h14;
  localparam logic [7:0] CMD_DMA_AUTO   = 8'h1C;
  localparam logic [7:0] CMD_DIRECT_IN  = 8'h20;
  localparam logic [7:0] CMD_REC_SINGLE = 8'h24;
  localparam logic [7:0] CMD_REC_AUTO   = 8'h2C;
  localparam logic [7:0] CMD_TIME_CONST = 8'h40;
  localparam logic [7:0] CMD_BLOCK_SIZE = 8'h48;
  localparam logic [7:0] CMD_SILENCE    = 8'h80;
  localparam logic [7:0] CMD_HALT       = 8'hD0;
  localparam logic [7:0] CMD_SPK_ON     = 8'hD1;
  localparam logic [7:0] CMD_SPK_OFF    = 8'hD3;
  localparam logic [7:0] CMD_CONTINUE   = 8'hD4;
  localparam logic [7:0] CMD_EXIT_AUTO  = 8'hDA;
  localparam logic [7:0] CMD_INVERT     = 8'hE0;
  localparam logic [7:0] CMD_VERSION    = 8'hE1;
  localparam logic [7:0] CMD_IDENT      = 8'hE2;
  localparam logic [7:0] CMD_TEST_WR    = 8'hE4;
  localparam logic [7:0] CMD_TEST_RD    = 8'hE8;
  localparam logic [7:0] CMD_IRQ        = 8'hF2;
  localparam logic [7:0] CMD_FIFO_CLR   = 8'hF8;

  // data constants
  localparam logic [7:0] RESET_ACK   = 8'hAA;
  localparam logic [7:0] SIGN_FLIP   = 8'h80;
  localparam logic [7:0] SILENCE_BYTE = 8'h80;
  localparam logic [7:0] STATUS_FULL = 8'h80;
  localparam logic [7:0] STATUS_NONE = 8'h00;
  localparam logic [7:0] CMD_PORT_RD = 8'h00;
  localparam logic [7:0] OPEN_BUS    = 8'hFF;
  localparam logic [7:0] VER_MAJOR   = 8'h02;
  localparam logic [7:0] VER_MINOR   = 8'h01;
  localparam logic [7:0] ID_BIAS     = 8'h96;  // -106 modulo 256

  localparam logic [7:0] IDENT_ADJ [0:7] = '{
    8'h01, 8'hFE, 8'hFC, 8'h08, 8'hF0, 8'h20, 8'h40, 8'h80
  };

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] port;
    logic [7:0] wr_data;
    logic [7:0] dma_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         rd_data;
    logic signed [15:0] sample_out;
    logic               dma_read_taken;
    logic               dma_write_valid;
    logic [7:0]         dma_write_data;
    logic               irq_pulse;
    logic [7:0]         time_constant;
    logic               speaker_on;
  } out_item_t;

  // fifo control from the command machine
  typedef struct packed {
    logic       clear;
    logic       pop;
    logic       push_a;
    logic       push_b;
    logic [7:0] data_a;
    logic [7:0] data_b;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [7:0] head;
    logic       nonempty;
  } fifo_stat_t;

  function automatic logic [7:0] ident_byte(input logic [7:0] v);
    logic [7:0] acc;
    acc = RESET_ACK;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        acc = acc + IDENT_ADJ[i];
      end
    end
    return acc + ID_BIAS;
  endfunction

endpackage

[design/adce_fifo.sv]
// ---------------------------------------------------------------------------
// adce_fifo
// Shifting read fifo: up to two pushes or one pop per transaction.
// ---------------------------------------------------------------------------
module adce_fifo #(
  parameter int FIFO_DEPTH = adce_pkg::FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  adce_pkg::fifo_ctrl_t   ctrl,
  output adce_pkg::fifo_stat_t   stat
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

  logic [7:0]    entry_r [FIFO_DEPTH];
  logic [7:0]    entry_nxt [FIFO_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] base, cnt_a;
  logic          ok_a, ok_b;

  always_comb begin
    base  = ctrl.clear ? '0 : cnt_r;
    ok_a  = ctrl.push_a && (base < DEPTH_C);
    cnt_a = base + CW'(ok_a);
    ok_b  = ctrl.push_b && (cnt_a < DEPTH_C);
    if (ctrl.pop) begin
      cnt_nxt = (cnt_r != '0) ? cnt_r - 1'b1 : '0;
    end else begin
      cnt_nxt = cnt_a + CW'(ok_b);
    end
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
      if (ctrl.pop) begin
        // the last entry keeps its value on a shift
        if (i < FIFO_DEPTH - 1) begin
          entry_nxt[i] = entry_r[i+1];
        end
      end else if (ok_a && base == CW'(i)) begin
        entry_nxt[i] = ctrl.data_a;
      end else if (ok_b && cnt_a == CW'(i)) begin
        entry_nxt[i] = ctrl.data_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CW'(1);
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        entry_r[i] <= (i == 0) ? adce_pkg::RESET_ACK : 8'h00;
      end
    end else if (en) begin
      cnt_r <= cnt_nxt;
      for (int i = 0; i < FIFO_DEPTH; i++) begin
        entry_r[i] <= entry_nxt[i];
      end
    end
  end

  assign stat.head     = entry_r[0];
  assign stat.nonempty = (cnt_r != '0);

endmodule

[design/audio_dsp_command_dma_engine.sv]
// ---------------------------------------------------------------------------
// audio_dsp_command_dma_engine
// Byte-port audio dsp: command machine, read fifo and 8-bit dma tick logic.
// ---------------------------------------------------------------------------
// result: registered, valid in the cycle after the transaction is accepted
// throughput: one transaction per cycle while in_stall is low; all state updates in the accept cycle
// in_stall rises only while a held result is stalled at the output register
// reset: synchronous active low; fifo holds 0xAA with count one, rest cleared
module audio_dsp_command_dma_engine #(
  parameter int FIFO_DEPTH = adce_pkg::FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  adce_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output adce_pkg::out_item_t  out_data
);

  logic        accept;
  logic        out_valid_r;
  adce_pkg::out_item_t out_r, res;

  logic        spk_r, spk_nxt;
  logic [15:0] dac_r, dac_nxt;
  logic [7:0]  tc_r, tc_nxt;
  logic [16:0] bl_r, bl_nxt;
  logic [16:0] bc_r, bc_nxt, bc_inc;
  logic        auto_r, auto_nxt;
  logic        sil_r, sil_nxt;
  logic        rec_r, rec_nxt;
  logic        act_r, act_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        hbn_r, hbn_nxt;
  logic [7:0]  test_r, test_nxt;

  adce_pkg::fifo_ctrl_t fctrl;
  adce_pkg::fifo_stat_t fstat;

  logic [7:0]  v;
  logic        len_done;
  logic [16:0] len_full;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign v        = in_data.wr_data;
  assign bc_inc   = bc_r + 17'd1;
  assign len_full = (bl_r | {1'b0, v, 8'h00}) + 17'd1;
  assign len_done = hbn_r;

  adce_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .ctrl  (fctrl),
    .stat  (fstat)
  );

  always_comb begin
    spk_nxt  = spk_r;
    dac_nxt  = dac_r;
    tc_nxt   = tc_r;
    bl_nxt   = bl_r;
    bc_nxt   = bc_r;
    auto_nxt = auto_r;
    sil_nxt  = sil_r;
    rec_nxt  = rec_r;
    act_nxt  = act_r;
    pend_nxt = pend_r;
    hbn_nxt  = hbn_r;
    test_nxt = test_r;
    fctrl    = '0;
    res      = '0;

    case (in_data.req_type)
      adce_pkg::REQ_WRITE: begin
        if (in_data.port == adce_pkg::PORT_RESET) begin
          if (v == 8'h00) begin
            spk_nxt      = 1'b0;
            dac_nxt      = '0;
            fctrl.clear  = 1'b1;
            fctrl.push_a = 1'b1;
            fctrl.data_a = adce_pkg::RESET_ACK;
          end
        end else if (in_data.port == adce_pkg::PORT_CMD) begin
          case (pend_r)
            adce_pkg::CMD_DIRECT_DAC: begin
              dac_nxt  = {v ^ adce_pkg::SIGN_FLIP, 8'h00};
              pend_nxt = adce_pkg::CMD_NONE;
            end
            adce_pkg::CMD_DMA_SINGLE, adce_pkg::CMD_REC_SINGLE,
            adce_pkg::CMD_BLOCK_SIZE, adce_pkg::CMD_SILENCE: begin
              // low length byte first, then high byte; the stored length is that value plus one
              if (!len_done) begin
                bl_nxt  = {9'd0, v};
                hbn_nxt = 1'b1;
              end else begin
                bl_nxt   = len_full;
                pend_nxt = adce_pkg::CMD_NONE;
                if (pend_r == adce_pkg::CMD_SILENCE) begin
                  bc_nxt   = '0;
                  sil_nxt  = 1'b1;
                  auto_nxt = 1'b0;
                end else if (pend_r != adce_pkg::CMD_BLOCK_SIZE) begin
                  bc_nxt   = '0;
                  sil_nxt  = 1'b0;
                  auto_nxt = 1'b0;
                  rec_nxt  = (pend_r == adce_pkg::CMD_REC_SINGLE);
                  act_nxt  = 1'b1;
                end
              end
            end
            adce_pkg::CMD_TIME_CONST: begin
              tc_nxt   = v;
              pend_nxt = adce_pkg::CMD_NONE;
            end
            adce_pkg::CMD_INVERT: begin
              fctrl.push_a = 1'b1;
              fctrl.data_a = ~v;
              pend_nxt     = adce_pkg::CMD_NONE;
            end
            adce_pkg::CMD_IDENT: begin
              res.dma_write_valid = 1'b1;
              res.dma_write_data  = adce_pkg::ident_byte(v);
              pend_nxt            = adce_pkg::CMD_NONE;
            end
            adce_pkg::CMD_TEST_WR: begin
              test_nxt = v;
              pend_nxt = adce_pkg::CMD_NONE;
            end
            default: begin
              pend_nxt = v;
              case (v)
                adce_pkg::CMD_DMA_SINGLE, adce_pkg::CMD_REC_SINGLE,
                adce_pkg::CMD_BLOCK_SIZE, adce_pkg::CMD_SILENCE: begin
                  hbn_nxt = 1'b0;
                end
                adce_pkg::CMD_DMA_AUTO, adce_pkg::CMD_REC_AUTO: begin
                  bc_nxt   = '0;
                  sil_nxt  = 1'b0;
                  auto_nxt = 1'b1;
                  rec_nxt  = (v == adce_pkg::CMD_REC_AUTO);
                  act_nxt  = 1'b1;
                end
                adce_pkg::CMD_DIRECT_IN: begin
                  fctrl.push_a = 1'b1;
                  fctrl.data_a = adce_pkg::SILENCE_BYTE;
                end
                adce_pkg::CMD_HALT:     act_nxt = 1'b0;
                adce_pkg::CMD_SPK_ON:   spk_nxt = 1'b1;
                adce_pkg::CMD_SPK_OFF:  spk_nxt = 1'b0;
                adce_pkg::CMD_CONTINUE: act_nxt = 1'b1;
                adce_pkg::CMD_EXIT_AUTO: begin
                  act_nxt  = 1'b0;
                  auto_nxt = 1'b0;
                end
                adce_pkg::CMD_VERSION: begin
                  fctrl.push_a = 1'b1;
                  fctrl.data_a = adce_pkg::VER_MAJOR;
                  fctrl.push_b = 1'b1;
                  fctrl.data_b = adce_pkg::VER_MINOR;
                end
                adce_pkg::CMD_TEST_RD: begin
                  fctrl.push_a = 1'b1;
                  fctrl.data_a = test_r;
                end
                adce_pkg::CMD_IRQ: res.irq_pulse = 1'b1;
                adce_pkg::CMD_FIFO_CLR: begin
                  fctrl.clear  = 1'b1;
                  fctrl.push_a = 1'b1;
                  fctrl.data_a = 8'h00;
                end
                default: ;
              endcase
            end
          endcase
        end
      end
      adce_pkg::REQ_READ: begin
        case (in_data.port)
          adce_pkg::PORT_RDATA: begin
            fctrl.pop   = 1'b1;
            res.rd_data = fstat.head;
          end
          adce_pkg::PORT_CMD:    res.rd_data = adce_pkg::CMD_PORT_RD;
          adce_pkg::PORT_STATUS: begin
            res.rd_data = fstat.nonempty ? adce_pkg::STATUS_FULL : adce_pkg::STATUS_NONE;
          end
          default:               res.rd_data = adce_pkg::OPEN_BUS;
        endcase
      end
      adce_pkg::REQ_TICK: begin
        if (act_r) begin
          if (!sil_r) begin
            if (!rec_r) begin
              dac_nxt            = {in_data.dma_data ^ adce_pkg::SIGN_FLIP, 8'h00};
              res.dma_read_taken = 1'b1;
            end else begin
              res.dma_write_valid = 1'b1;
              res.dma_write_data  = adce_pkg::SILENCE_BYTE;
            end
          end else begin
            dac_nxt = '0;
          end
          bc_nxt = bc_inc;
          // end of block: counter equal to length after the increment
          if (bc_inc == bl_r) begin
            bc_nxt        = '0;
            res.irq_pulse = 1'b1;
            if (!auto_r) begin
              act_nxt = 1'b0;
            end
          end
          if (!spk_r) begin
            dac_nxt = '0;
          end
          res.sample_out = dac_nxt;
        end
      end
      default: ;
    endcase

    res.time_constant = tc_nxt;
    res.speaker_on    = spk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spk_r       <= 1'b0;
      dac_r       <= '0;
      tc_r        <= '0;
      bl_r        <= '0;
      bc_r        <= '0;
      auto_r      <= 1'b0;
      sil_r       <= 1'b0;
      rec_r       <= 1'b0;
      act_r       <= 1'b0;
      pend_r      <= adce_pkg::CMD_NONE;
      hbn_r       <= 1'b0;
      test_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        spk_r       <= spk_nxt;
        dac_r       <= dac_nxt;
        tc_r        <= tc_nxt;
        bl_r        <= bl_nxt;
        bc_r        <= bc_nxt;
        auto_r      <= auto_nxt;
        sil_r       <= sil_nxt;
        rec_r       <= rec_nxt;
        act_r       <= act_nxt;
        pend_r      <= pend_nxt;
        hbn_r       <= hbn_nxt;
        test_r      <= test_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "audio_dsp_command_dma_engine_assert.svh"

  // every accepted transaction shows up in the result register
  `ADCE_ASSERT_NEXT(a_accept_to_out, clk, rst_n, accept, out_valid_r)
  // a stalled result is never overwritten
  `ADCE_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !accept)
  // a dma byte is either consumed or written, never both in one result
  `ADCE_ASSERT_NOW(a_dma_dir, clk, rst_n, out_valid_r && out_r.dma_read_taken,
                   !out_r.dma_write_valid)

endmodule
